[design/ookd_pkg.sv]
// Shared types and constants for the OOK pulse-width frame decoder.
package ookd_pkg;

  localparam int FRAME_BITS = 12;
  localparam int COUNT_W    = $clog2(FRAME_BITS + 1);
  localparam int CODE_W     = 12;
  localparam int SERIAL_W   = 8;
  localparam int BUTTON_W   = 4;
  localparam int EXT_W      = (FRAME_BITS > CODE_W) ? FRAME_BITS : CODE_W;
  localparam int LEN_W      = 24;
  localparam int TIME_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [COUNT_W-1:0] LAST_BIT = COUNT_W'(FRAME_BITS - 1);

  localparam logic [TIME_W-1:0] SHORT_TIME_RST     = 16'd320;
  localparam logic [TIME_W-1:0] LONG_TIME_RST      = 16'd640;
  localparam logic [TIME_W-1:0] TIME_TOLERANCE_RST = 16'd150;
  localparam logic [LEN_W-1:0]  GUARD_GAP_RST      = 24'd9000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_TIME     = 3'd0,
    REG_LONG_TIME      = 3'd1,
    REG_TIME_TOLERANCE = 3'd2,
    REG_GUARD_GAP      = 3'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_state_t;

  // Result of the duration window check
  typedef struct packed {
    logic is_short;
    logic is_long;
  } window_hit_t;

endpackage

[design/ookd_if.sv]
// Channel interfaces: phase input, decoded code output, register write port.
interface ookd_phase_if;
  import ookd_pkg::*;
  logic             valid;
  logic             ready;
  logic             line_level;
  logic [LEN_W-1:0] phase_length;
  modport source (output valid, output line_level, output phase_length, input ready);
  modport sink (input valid, input line_level, input phase_length, output ready);
endinterface

interface ookd_code_if;
  import ookd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   frame_code;
  logic [SERIAL_W-1:0] serial_part;
  logic [BUTTON_W-1:0] button_part;
  modport source (output valid, output frame_code, output serial_part, output button_part,
                  input ready);
  modport sink (input valid, input frame_code, input serial_part, input button_part,
                output ready);
endinterface

interface ookd_cfg_if;
  import ookd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/ookd_window.sv]
// Classifies a phase length against the short and long tolerance windows.
module ookd_window
  import ookd_pkg::*;
(
  input  logic [LEN_W-1:0]  phase_length,
  input  logic [TIME_W-1:0] short_time,
  input  logic [TIME_W-1:0] long_time,
  input  logic [TIME_W-1:0] time_tolerance,
  output window_hit_t       hit
);

  logic [TIME_W-1:0] short_lo;
  logic [TIME_W-1:0] long_lo;
  logic [TIME_W:0]   short_hi;
  logic [TIME_W:0]   long_hi;

  // lower bound clamps at zero, upper bound carries one extra bit
  assign short_lo = (short_time > time_tolerance) ? short_time - time_tolerance : '0;
  assign long_lo  = (long_time > time_tolerance) ? long_time - time_tolerance : '0;
  assign short_hi = {1'b0, short_time} + {1'b0, time_tolerance};
  assign long_hi  = {1'b0, long_time} + {1'b0, time_tolerance};

  assign hit.is_short = (phase_length >= LEN_W'(short_lo)) &&
                        (phase_length <= LEN_W'(short_hi));
  assign hit.is_long  = (phase_length >= LEN_W'(long_lo)) &&
                        (phase_length <= LEN_W'(long_hi));

endmodule

[design/ook_pulse_width_frame_decoder_unit.sv]
// A frame code is registered and appears on the output in the cycle after its last data phase transfer.
// Throughput: one phase per cycle; a new phase enters in the cycle a waiting code transfers.
// Input stalls only while an undelivered code sits in the output register.
// Reset (rst, synchronous): state idle, shift word and bit count zero, output empty,
// timing registers back to 320 / 640 / 150 / 9000.
module ook_pulse_width_frame_decoder_unit
  import ookd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ookd_phase_if.sink   phase,
  ookd_code_if.source  code,
  ookd_cfg_if.sink     cfg
);

  logic [TIME_W-1:0]  short_time;
  logic [TIME_W-1:0]  long_time;
  logic [TIME_W-1:0]  time_tolerance;
  logic [LEN_W-1:0]   guard_gap;

  phase_state_t          state;
  phase_state_t          state_next;
  logic [FRAME_BITS-1:0] shift_word;
  logic [FRAME_BITS-1:0] shift_word_next;
  logic [COUNT_W-1:0]    bits_taken;
  logic [COUNT_W-1:0]    bits_taken_next;

  logic                  out_valid;
  logic [CODE_W-1:0]     frame_code;
  logic                  emit;
  logic                  accept;
  logic [EXT_W-1:0]      word_ext;
  window_hit_t           hit;

  assign cfg.ready   = 1'b1;
  assign phase.ready = !out_valid || code.ready;
  assign accept      = phase.valid && phase.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_time     <= SHORT_TIME_RST;
      long_time      <= LONG_TIME_RST;
      time_tolerance <= TIME_TOLERANCE_RST;
      guard_gap      <= GUARD_GAP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SHORT_TIME:     short_time     <= cfg.data[TIME_W-1:0];
        REG_LONG_TIME:      long_time      <= cfg.data[TIME_W-1:0];
        REG_TIME_TOLERANCE: time_tolerance <= cfg.data[TIME_W-1:0];
        REG_GUARD_GAP:      guard_gap      <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  ookd_window u_window (
    .phase_length   (phase.phase_length),
    .short_time     (short_time),
    .long_time      (long_time),
    .time_tolerance (time_tolerance),
    .hit            (hit)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      PH_IDLE: begin
        if (phase.line_level && phase.phase_length >= LEN_W'(long_time)) begin
          state_next = PH_SYNC;
        end
      end
      PH_SYNC: begin
        if (!phase.line_level && phase.phase_length >= LEN_W'(short_time)) begin
          state_next = PH_DATA;
        end else if (phase.line_level && phase.phase_length < LEN_W'(long_time)) begin
          state_next = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (!phase.line_level) begin
          if (!hit.is_short && !hit.is_long) begin
            state_next = PH_IDLE;
          end else if (bits_taken == LAST_BIT) begin
            state_next = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        if (phase.phase_length >= guard_gap) begin
          state_next = PH_IDLE;
        end
      end
      default: state_next = PH_IDLE;
    endcase
  end

  // shift word, bit count and result
  always_comb begin
    shift_word_next = shift_word;
    bits_taken_next = bits_taken;
    emit            = 1'b0;
    case (state)
      PH_SYNC: begin
        if (!phase.line_level && phase.phase_length >= LEN_W'(short_time)) begin
          shift_word_next = '0;
          bits_taken_next = '0;
        end
      end
      PH_DATA: begin
        if (!phase.line_level && (hit.is_short || hit.is_long)) begin
          // short window wins when both match
          shift_word_next = {shift_word[FRAME_BITS-2:0], !hit.is_short};
          bits_taken_next = bits_taken + COUNT_W'(1);
          emit            = (bits_taken == LAST_BIT);
        end
      end
      default: ;
    endcase
  end

  assign word_ext = EXT_W'(shift_word_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= PH_IDLE;
      shift_word <= '0;
      bits_taken <= '0;
    end else if (accept) begin
      state      <= state_next;
      shift_word <= shift_word_next;
      bits_taken <= bits_taken_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (code.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      frame_code <= word_ext[CODE_W-1:0];
    end
  end

  assign code.valid       = out_valid;
  assign code.frame_code  = frame_code;
  assign code.serial_part = frame_code[SERIAL_W-1:0];
  assign code.button_part = frame_code[SERIAL_W +: BUTTON_W];

`ifndef SYNTHESIS
  a_code_from_data: assert property (@(posedge clk) disable iff (rst)
    $rose(code.valid) |-> $past(state) == PH_DATA)
    else $error("code appeared without a data phase");

  a_done_after_code: assert property (@(posedge clk) disable iff (rst)
    $rose(code.valid) |-> state == PH_DONE)
    else $error("frame completed but decoder not in done state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == PH_DATA |-> bits_taken < COUNT_W'(FRAME_BITS))
    else $error("bit count overran frame length");

  a_emit_only_in_data: assert property (@(posedge clk) disable iff (rst)
    accept && state != PH_DATA |=> !$rose(code.valid))
    else $error("code produced outside data state");
`endif

endmodule
